### design/bmpd_pkg.sv
// Shared types and constants of the BMP stream pixel decoder.
// Used by the front parser, the job queue, the back executor and the top level.
package bmpd_pkg;

  localparam logic [1:0] ACT_GAMMA = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [15:0] BMP_SIG = 16'h4D42;

  localparam int QUEUE_DEPTH = 4;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_STRIP = 2'd0;
  localparam logic [1:0] REG_RED   = 2'd1;
  localparam logic [1:0] REG_GREEN = 2'd2;
  localparam logic [1:0] REG_BLUE  = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GAMMA,
    OP_PAL,
    OP_DIRECT,
    OP_INDEX
  } op_e;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DONE,
    TAIL_ERROR
  } tail_e;

  typedef enum logic [1:0] {
    DEP_1,
    DEP_4,
    DEP_8
  } depth_e;

  typedef struct packed {
    op_e         op;
    tail_e       tail;
    logic [23:0] data;
    logic [7:0]  entry;
    logic [15:0] row;
    logic [9:0]  col;
    logic [3:0]  count;
    depth_e      depth;
    logic        order24;
  } job_t;

  typedef struct packed {
    logic [1:0] red;
    logic [1:0] green;
    logic [1:0] blue;
  } slots_t;

endpackage

### design/bmpd_fifo.sv
// Short job queue between the front parser and the back executor.
// Depends on bmpd_pkg for the job type and depth.
module bmpd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bmpd_pkg::job_t push_job_i,
  input  logic          pop_i,
  output bmpd_pkg::job_t head_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int AW = $clog2(bmpd_pkg::QUEUE_DEPTH);

  bmpd_pkg::job_t mem_q [bmpd_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == AW'(0) + (AW+1)'(bmpd_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

### design/bmpd_front.sv
// Front parser: takes one input beat per cycle, walks the BMP headers and
// the pixel rows, and turns each beat into at most one job. Uses bmpd_pkg.
module bmpd_front #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_STRIP       = 1023
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [1:0]     action_i,
  input  logic [7:0]     file_byte_i,
  input  logic [7:0]     table_index_i,
  input  logic [7:0]     table_value_i,
  input  logic [9:0]     strip_width_i,
  output logic           push_o,
  output bmpd_pkg::job_t job_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_PALSKIP  = 3'd2;
  localparam logic [2:0] PH_PALETTE  = 3'd3;
  localparam logic [2:0] PH_DATASKIP = 3'd4;
  localparam logic [2:0] PH_PIXELS   = 3'd5;

  localparam logic [15:0] MAX_STRIP_W = 16'(MAX_STRIP);
  localparam logic [32:0] PAL_MAX     = 33'(PALETTE_ENTRIES);

  logic [2:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d, shift_q, shift_d, dstart_q, dstart_d, dib_q, dib_d;
  logic [15:0] width_q, width_d, height_q, height_d, bpp_q, bpp_d;
  logic        top_q, top_d;
  logic [31:0] raw_q, raw_d, ptarget_q, ptarget_d;
  logic [8:0]  ccount_q, ccount_d, pentry_q, pentry_d;
  logic [1:0]  pbyte_q, pbyte_d;
  logic [9:0]  lcols_q, lcols_d;
  logic [17:0] rbytes_q, rbytes_d, rbc_q, rbc_d, pcol_q, pcol_d;
  logic [15:0] rowc_q, rowc_d;
  logic [1:0]  pph_q, pph_d;

  logic [31:0] pos_n, sh_new, neg_v, hv;
  logic [15:0] h16, d_eff, lw16, row_dst;
  logic [9:0]  lw;
  logic [21:0] dw, rw;
  logic [17:0] rb;
  logic        pix, last_row, do_fail, do_endhdr, do_begin, core;
  logic [32:0] ccand, pstart;
  logic [20:0] base, rem21;
  logic [3:0]  ppb, cnt;
  logic [1:0]  lim;

  always_comb begin
    pos_n  = pos_q + 32'd1;
    sh_new = {file_byte_i, shift_q[31:8]};
    h16    = sh_new[31:16];
    core   = (dib_q == 32'd12);
    neg_v  = 32'd0 - sh_new;
    hv     = sh_new[31] ? neg_v : sh_new;
    d_eff  = (phase_q == PH_HEADER && core && pos_q == 32'd25) ? h16 : bpp_q;
    pix    = (d_eff == 16'd1) || (d_eff == 16'd4) || (d_eff == 16'd8) ||
             (d_eff == 16'd24) || (d_eff == 16'd32);
    lw16   = (width_q > {6'd0, strip_width_i}) ? {6'd0, strip_width_i} : width_q;
    if (lw16 > MAX_STRIP_W) lw16 = MAX_STRIP_W;
    lw     = lw16[9:0];
    case (d_eff)
      16'd1:   dw = {6'd0, width_q};
      16'd4:   dw = {4'd0, width_q, 2'd0};
      16'd8:   dw = {3'd0, width_q, 3'd0};
      16'd24:  dw = {2'd0, width_q, 4'd0} + {3'd0, width_q, 3'd0};
      16'd32:  dw = {1'd0, width_q, 5'd0};
      default: dw = '0;
    endcase
    rw     = (dw + 22'd31) >> 5;
    rb     = pix ? {rw[15:0], 2'd0} : 18'd0;
    ccand  = (raw_q == 32'd0) ? (33'd1 << d_eff[3:0]) : {1'b0, raw_q};
    pstart = 33'd14 + {1'b0, dib_q};
    row_dst  = top_q ? rowc_q : (height_q - 16'd1 - rowc_q);
    last_row = ({1'b0, rowc_q} + 17'd1) == {1'b0, height_q};
    case (bpp_q)
      16'd8:   ppb = 4'd1;
      16'd4:   ppb = 4'd2;
      default: ppb = 4'd8;
    endcase
    case (bpp_q)
      16'd8:   base = {3'd0, rbc_q};
      16'd4:   base = {2'd0, rbc_q, 1'b0};
      default: base = {rbc_q, 3'd0};
    endcase
    rem21 = {11'd0, lcols_q} - base;
    cnt   = (rem21 < {17'd0, ppb}) ? rem21[3:0] : ppb;
    lim   = (bpp_q == 16'd32) ? 2'd3 : 2'd2;
  end

  always_comb begin
    phase_d = phase_q;  pos_d = pos_q;  shift_d = shift_q;  dstart_d = dstart_q;
    dib_d = dib_q;  width_d = width_q;  height_d = height_q;  bpp_d = bpp_q;
    top_d = top_q;  raw_d = raw_q;  ptarget_d = ptarget_q;  ccount_d = ccount_q;
    pentry_d = pentry_q;  pbyte_d = pbyte_q;  lcols_d = lcols_q;  rbytes_d = rbytes_q;
    rbc_d = rbc_q;  rowc_d = rowc_q;  pph_d = pph_q;  pcol_d = pcol_q;
    job_o = '0;
    job_o.op = bmpd_pkg::OP_NONE;
    job_o.tail = bmpd_pkg::TAIL_NONE;
    job_o.depth = bmpd_pkg::DEP_8;
    job_o.row = row_dst;
    do_fail = 1'b0;
    do_endhdr = 1'b0;
    do_begin = 1'b0;
    if (accept_i) begin
      case (action_i)
        bmpd_pkg::ACT_GAMMA: begin
          job_o.op    = bmpd_pkg::OP_GAMMA;
          job_o.entry = table_index_i;
          job_o.data  = {16'd0, table_value_i};
        end
        bmpd_pkg::ACT_START: begin
          pos_d = '0;  shift_d = '0;  dstart_d = '0;  dib_d = '0;  width_d = '0;
          height_d = '0;  top_d = 1'b0;  bpp_d = '0;  ccount_d = '0;  raw_d = '0;
          rowc_d = '0;  rbc_d = '0;  pentry_d = '0;  pbyte_d = '0;  pph_d = '0;
          pcol_d = '0;
          phase_d = PH_HEADER;
        end
        bmpd_pkg::ACT_BYTE: begin
          if (phase_q != PH_IDLE) begin
            pos_d = pos_n;
            shift_d = sh_new;
            case (phase_q)
              PH_HEADER: begin
                if (pos_q == 32'd1) begin
                  if (h16 != bmpd_pkg::BMP_SIG) do_fail = 1'b1;
                end else if (pos_q == 32'd13) begin
                  dstart_d = sh_new;
                end else if (pos_q == 32'd17) begin
                  dib_d = sh_new;
                  if (sh_new != 32'd12 && sh_new < 32'd40) do_fail = 1'b1;
                end else if (pos_q >= 32'd18 && core) begin
                  case (pos_q)
                    32'd19: width_d = h16;
                    32'd21: begin
                      height_d = h16;
                      top_d = 1'b0;
                    end
                    32'd23: if (h16 != 16'd1) do_fail = 1'b1;
                    32'd25: begin
                      bpp_d = h16;
                      do_endhdr = 1'b1;
                    end
                    default: ;
                  endcase
                end else if (pos_q >= 32'd18) begin
                  case (pos_q)
                    32'd21: begin
                      if (sh_new > 32'd65535) do_fail = 1'b1;
                      else width_d = sh_new[15:0];
                    end
                    32'd25: begin
                      top_d = sh_new[31];
                      if (hv > 32'd65535) do_fail = 1'b1;
                      else height_d = hv[15:0];
                    end
                    32'd27: if (h16 != 16'd1) do_fail = 1'b1;
                    32'd29: bpp_d = h16;
                    32'd33: if (sh_new != 32'd0) do_fail = 1'b1;
                    32'd49: raw_d = sh_new;
                    32'd53: do_endhdr = 1'b1;
                    default: ;
                  endcase
                end
              end
              PH_PALSKIP: begin
                if (pos_n >= ptarget_q) phase_d = PH_PALETTE;
              end
              PH_PALETTE: begin
                if (pbyte_q + 2'd1 == (core ? 2'd3 : 2'd0)) begin
                  pbyte_d = '0;
                  job_o.op = bmpd_pkg::OP_PAL;
                  job_o.entry = pentry_q[7:0];
                  job_o.data = core ? sh_new[31:8] : sh_new[23:0];
                  pentry_d = pentry_q + 9'd1;
                  if (pentry_q + 9'd1 >= ccount_q) do_begin = 1'b1;
                end else begin
                  pbyte_d = pbyte_q + 2'd1;
                end
              end
              PH_DATASKIP: begin
                if (pos_n == dstart_q) phase_d = PH_PIXELS;
              end
              default: begin
                if (bpp_q == 16'd32 || bpp_q == 16'd24) begin
                  if (pph_q == lim) begin
                    pph_d = '0;
                    pcol_d = pcol_q + 18'd1;
                    if (pcol_q < {8'd0, lcols_q}) begin
                      job_o.op = bmpd_pkg::OP_DIRECT;
                      job_o.col = pcol_q[9:0];
                      job_o.order24 = (bpp_q == 16'd24);
                      job_o.data = (bpp_q == 16'd24) ? sh_new[31:8] : sh_new[23:0];
                      if (pcol_q[9:0] == lcols_q - 10'd1 && last_row) begin
                        job_o.tail = bmpd_pkg::TAIL_DONE;
                        phase_d = PH_IDLE;
                      end
                    end
                  end else begin
                    pph_d = pph_q + 2'd1;
                  end
                end else if (base < {11'd0, lcols_q}) begin
                  job_o.op = bmpd_pkg::OP_INDEX;
                  job_o.data = {16'd0, file_byte_i};
                  job_o.col = base[9:0];
                  job_o.count = cnt;
                  job_o.depth = (bpp_q == 16'd8) ? bmpd_pkg::DEP_8 :
                                (bpp_q == 16'd4) ? bmpd_pkg::DEP_4 : bmpd_pkg::DEP_1;
                  if (rem21 <= {17'd0, ppb} && last_row) begin
                    job_o.tail = bmpd_pkg::TAIL_DONE;
                    phase_d = PH_IDLE;
                  end
                end
                if (rbc_q + 18'd1 >= rbytes_q) begin
                  rbc_d = '0;
                  rowc_d = rowc_q + 16'd1;
                  pph_d = '0;
                  pcol_d = '0;
                end else begin
                  rbc_d = rbc_q + 18'd1;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
    if (do_endhdr) begin
      if (d_eff < 16'd16) begin
        if (ccand > PAL_MAX || pstart[32]) begin
          do_fail = 1'b1;
        end else begin
          ccount_d = ccand[8:0];
          ptarget_d = pstart[31:0];
          pentry_d = '0;
          pbyte_d = '0;
          phase_d = (pos_n >= pstart[31:0]) ? PH_PALETTE : PH_PALSKIP;
        end
      end else begin
        do_begin = 1'b1;
      end
    end
    if (do_begin) begin
      lcols_d = lw;
      rbytes_d = rb;
      rowc_d = '0;
      rbc_d = '0;
      pph_d = '0;
      pcol_d = '0;
      if (!pix || height_q == 16'd0 || lw == 10'd0) begin
        phase_d = PH_IDLE;
        job_o.tail = bmpd_pkg::TAIL_DONE;
      end else if (dstart_q < pos_n) begin
        do_fail = 1'b1;
      end else begin
        phase_d = (dstart_q == pos_n) ? PH_PIXELS : PH_DATASKIP;
      end
    end
    if (do_fail) begin
      phase_d = PH_IDLE;
      job_o.tail = bmpd_pkg::TAIL_ERROR;
    end
    push_o = (job_o.op != bmpd_pkg::OP_NONE) || (job_o.tail != bmpd_pkg::TAIL_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;  pos_q <= '0;  shift_q <= '0;  dstart_q <= '0;  dib_q <= '0;
      width_q <= '0;  height_q <= '0;  bpp_q <= '0;  top_q <= 1'b0;  raw_q <= '0;
      ptarget_q <= '0;  ccount_q <= '0;  pentry_q <= '0;  pbyte_q <= '0;
      lcols_q <= '0;  rbytes_q <= '0;  rbc_q <= '0;  rowc_q <= '0;  pph_q <= '0;
      pcol_q <= '0;
    end else begin
      phase_q <= phase_d;  pos_q <= pos_d;  shift_q <= shift_d;  dstart_q <= dstart_d;
      dib_q <= dib_d;  width_q <= width_d;  height_q <= height_d;  bpp_q <= bpp_d;
      top_q <= top_d;  raw_q <= raw_d;  ptarget_q <= ptarget_d;  ccount_q <= ccount_d;
      pentry_q <= pentry_d;  pbyte_q <= pbyte_d;  lcols_q <= lcols_d;
      rbytes_q <= rbytes_d;  rbc_q <= rbc_d;  rowc_q <= rowc_d;  pph_q <= pph_d;
      pcol_q <= pcol_d;
    end
  end

endmodule

### design/bmpd_back.sv
// Back executor: runs queued jobs in order against the gamma and palette
// memories and drives the registered result port. Uses bmpd_pkg.
module bmpd_back #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  bmpd_pkg::job_t       job_i,
  output logic                 pop_o,
  input  bmpd_pkg::slots_t     slots_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [1:0]           kind_o,
  output logic [15:0]          out_row_o,
  output logic [9:0]           out_col_o,
  output logic [7:0]           slot0_o,
  output logic [7:0]           slot1_o,
  output logic [7:0]           slot2_o,
  output logic                 last_o
);

  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GWR  = 4'd1;
  localparam logic [3:0] S_G0   = 4'd2;
  localparam logic [3:0] S_G1   = 4'd3;
  localparam logic [3:0] S_G2   = 4'd4;
  localparam logic [3:0] S_G3   = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PEM  = 4'd7;
  localparam logic [3:0] S_TAIL = 4'd8;

  logic [7:0]  gamma_mem [256];
  logic [23:0] pal_mem [PALETTE_ENTRIES];

  logic [3:0]     st_q, st_d, j_q, j_d;
  bmpd_pkg::job_t job_q, job_d;
  logic [7:0]     r_q, r_d, g_q, g_d, gam_rd_q, gam_raddr, idx8;
  logic [23:0]    pal_rd_q, rgb_s;
  logic           gam_re, gam_we, pal_re, pal_we, out_free, load_out;
  logic [PAL_AW-1:0] pal_raddr;
  logic [3:0]     next_tail;

  logic        ov_q, ov_d, last_q, last_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] row_q, row_d;
  logic [9:0]  col_q, col_d;
  logic [23:0] sl_q, sl_d;

  function automatic logic [23:0] place(input logic [23:0] s, input logic [1:0] slot,
                                        input logic [7:0] v);
    logic [23:0] t;
    t = s;
    case (slot)
      2'd0:    t[7:0]   = v;
      2'd1:    t[15:8]  = v;
      2'd2:    t[23:16] = v;
      default: ;
    endcase
    return t;
  endfunction

  assign out_free  = !ov_q || !out_stall_i;
  assign next_tail = (job_q.tail != bmpd_pkg::TAIL_NONE) ? S_TAIL : S_IDLE;

  always_comb begin
    if (job_q.order24) begin
      rgb_s = place(place(place(24'd0, slots_i.blue, gam_rd_q), slots_i.green, g_q),
                    slots_i.red, r_q);
    end else begin
      rgb_s = place(place(place(24'd0, slots_i.red, r_q), slots_i.green, g_q),
                    slots_i.blue, gam_rd_q);
    end
    case (job_q.depth)
      bmpd_pkg::DEP_8: idx8 = job_q.data[7:0];
      bmpd_pkg::DEP_4: idx8 = {4'd0, j_q[0] ? job_q.data[3:0] : job_q.data[7:4]};
      default:         idx8 = {7'd0, job_q.data[3'd7 - j_q[2:0]]};
    endcase
    pal_raddr = idx8[PAL_AW-1:0];
  end

  always_comb begin
    st_d = st_q;  j_d = j_q;  job_d = job_q;  r_d = r_q;  g_d = g_q;
    pop_o = 1'b0;  gam_re = 1'b0;  gam_we = 1'b0;  pal_re = 1'b0;  pal_we = 1'b0;
    gam_raddr = job_q.data[23:16];
    load_out = 1'b0;
    kind_d = kind_q;  row_d = row_q;  col_d = col_q;  sl_d = sl_q;  last_d = last_q;
    case (st_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          j_d = '0;
          case (job_i.op)
            bmpd_pkg::OP_GAMMA:  st_d = S_GWR;
            bmpd_pkg::OP_PAL:    st_d = S_G0;
            bmpd_pkg::OP_DIRECT: st_d = S_G0;
            bmpd_pkg::OP_INDEX:  st_d = S_PRD;
            default:             st_d = S_TAIL;
          endcase
        end
      end
      S_GWR: begin
        gam_we = 1'b1;
        st_d = S_IDLE;
      end
      S_G0: begin
        gam_re = 1'b1;
        st_d = S_G1;
      end
      S_G1: begin
        r_d = gam_rd_q;
        gam_re = 1'b1;
        gam_raddr = job_q.data[15:8];
        st_d = S_G2;
      end
      S_G2: begin
        g_d = gam_rd_q;
        gam_re = 1'b1;
        gam_raddr = job_q.data[7:0];
        st_d = S_G3;
      end
      S_G3: begin
        if (job_q.op == bmpd_pkg::OP_PAL) begin
          pal_we = 1'b1;
          st_d = next_tail;
        end else if (out_free) begin
          load_out = 1'b1;
          kind_d = bmpd_pkg::KIND_PIXEL;
          row_d = job_q.row;
          col_d = job_q.col;
          sl_d = rgb_s;
          last_d = (job_q.tail == bmpd_pkg::TAIL_NONE);
          st_d = next_tail;
        end
      end
      S_PRD: begin
        pal_re = 1'b1;
        st_d = S_PEM;
      end
      S_PEM: begin
        if (out_free) begin
          load_out = 1'b1;
          kind_d = bmpd_pkg::KIND_PIXEL;
          row_d = job_q.row;
          col_d = job_q.col + {6'd0, j_q};
          sl_d = pal_rd_q;
          last_d = (j_q == job_q.count - 4'd1) && (job_q.tail == bmpd_pkg::TAIL_NONE);
          if (j_q == job_q.count - 4'd1) begin
            st_d = next_tail;
          end else begin
            j_d = j_q + 4'd1;
            st_d = S_PRD;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          load_out = 1'b1;
          kind_d = (job_q.tail == bmpd_pkg::TAIL_DONE) ? bmpd_pkg::KIND_DONE :
                   bmpd_pkg::KIND_ERROR;
          row_d = '0;
          col_d = '0;
          sl_d = '0;
          last_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    ov_d = load_out ? 1'b1 : (ov_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (gam_we) gamma_mem[job_q.entry] <= job_q.data[7:0];
    if (gam_re) gam_rd_q <= gamma_mem[gam_raddr];
    if (pal_we) pal_mem[job_q.entry[PAL_AW-1:0]] <= rgb_s;
    if (pal_re) pal_rd_q <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    r_q <= r_d;
    g_q <= g_d;
    kind_q <= kind_d;
    row_q <= row_d;
    col_q <= col_d;
    sl_q <= sl_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      j_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      j_q <= j_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign slot0_o     = sl_q[7:0];
  assign slot1_o     = sl_q[15:8];
  assign slot2_o     = sl_q[23:16];
  assign last_o      = last_q;

endmodule

### design/bmp_stream_pixel_decoder.sv
// Top level of the BMP stream pixel decoder: configuration registers, the
// front parser, the job queue and the back executor. Uses bmpd_pkg.
//
// The decoder takes a BMP file one byte per input beat (action 2) after a
// start beat (action 1), and gamma table loads (action 0) at any time before
// a file. The front parser handles every input beat as it is taken: it checks
// the headers, tracks rows, columns and padding, and queues at most one job
// per beat. It stalls only when the four-entry job queue is full. The back
// executor runs jobs in order. Gamma loads and palette entries both use
// the single-ported gamma memory. A 24- or 32-bit pixel passes through three
// gamma reads, then the result. Each palette pixel needs a palette read state
// and then an output state because the palette memory read is registered, so
// a 1-bit-per-pixel byte yields up to eight pixels one after another. The
// finish or error result has a state of its own. A finished result waits
// in the output register while the next job is already being worked on.
// Configuration registers sit at byte addresses 0 (strip width), 4, 8 and 12
// (red, green and blue output slots) and must only be written while the
// decoder is idle.
module bmp_stream_pixel_decoder #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_STRIP       = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  file_byte_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] out_row_o,
  output logic [9:0]  out_col_o,
  output logic [7:0]  slot0_o,
  output logic [7:0]  slot1_o,
  output logic [7:0]  slot2_o,
  output logic        last_o
);

  logic [9:0]       strip_q;
  bmpd_pkg::slots_t slots_q;
  logic             wr_en, accept, push, pop, full, empty;
  bmpd_pkg::job_t   push_job, head_job;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes complete in the access phase of the bus transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 10'd144;
      slots_q.red <= 2'd0;
      slots_q.green <= 2'd1;
      slots_q.blue <= 2'd2;
    end else if (wr_en) begin
      case (paddr[3:2])
        bmpd_pkg::REG_STRIP: strip_q <= pwdata[9:0];
        bmpd_pkg::REG_RED:   slots_q.red <= pwdata[1:0];
        bmpd_pkg::REG_GREEN: slots_q.green <= pwdata[1:0];
        bmpd_pkg::REG_BLUE:  slots_q.blue <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bmpd_pkg::REG_STRIP: prdata = {22'd0, strip_q};
      bmpd_pkg::REG_RED:   prdata = {30'd0, slots_q.red};
      bmpd_pkg::REG_GREEN: prdata = {30'd0, slots_q.green};
      bmpd_pkg::REG_BLUE:  prdata = {30'd0, slots_q.blue};
      default:             prdata = '0;
    endcase
  end

  // The front takes a beat whenever the queue has room for its job.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bmpd_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .MAX_STRIP      (MAX_STRIP)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (action_i),
    .file_byte_i   (file_byte_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .strip_width_i (strip_q),
    .push_o        (push),
    .job_o         (push_job)
  );

  bmpd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .full_o     (full),
    .empty_o    (empty)
  );

  bmpd_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .slots_i     (slots_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .slot0_o     (slot0_o),
    .slot1_o     (slot1_o),
    .slot2_o     (slot2_o),
    .last_o      (last_o)
  );

endmodule
